>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property check.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Implication with an antecedent and a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication with the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sflx_pkg.sv
// ----------------------------------------------------------------------------
// sflx_pkg
// Types and constants shared by the frame parser modules.
// ----------------------------------------------------------------------------
package sflx_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;
    localparam int M_DATA_W  = 4 * BYTE_W;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'd1;

    // Reset values of the registers
    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RST = 8'd250;

    // One result beat
    typedef struct packed {
        logic              frame_good;
        logic              frame_end;
        logic [BYTE_W-1:0] frame_length;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] data_byte;
    } sflx_result_t;

endpackage

>>> hw/rtl/sflx_parser.sv
// ----------------------------------------------------------------------------
// sflx_parser
// Deframing state machine: one byte per step, at most one result per step.
// ----------------------------------------------------------------------------
module sflx_parser
    import sflx_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,        // consume byte_in this cycle
    input  logic [BYTE_W-1:0] byte_in,
    input  logic [BYTE_W-1:0] start_byte,
    input  logic [BYTE_W-1:0] max_length,
    output logic              res_valid,   // byte_in yields a result
    output sflx_result_t      res
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHK
    } phase_t;

    phase_t            phase_reg,  phase_next;
    logic [BYTE_W-1:0] type_reg,   type_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] count_reg,  count_next;
    logic [BYTE_W-1:0] xor_reg,    xor_next;
    logic [BYTE_W-1:0] count_inc;

    assign count_inc = count_reg + BYTE_W'(1);

    always_comb begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        length_next = length_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.frame_type   = type_reg;
        res.frame_length = length_reg;
        case (phase_reg)
            PH_TYPE: begin
                type_next  = byte_in;
                xor_next   = byte_in;
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                length_next = byte_in;
                if (byte_in > max_length) begin
                    phase_next = PH_HUNT;
                end else begin
                    xor_next   = xor_reg ^ byte_in;
                    count_next = '0;
                    phase_next = (byte_in == '0) ? PH_CHK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                res_valid      = 1'b1;
                res.data_byte  = byte_in;
                res.byte_index = count_reg;
                xor_next       = xor_reg ^ byte_in;
                count_next     = count_inc;
                if (count_inc >= length_reg) begin
                    phase_next = PH_CHK;
                end
            end
            PH_CHK: begin
                res_valid      = 1'b1;
                res.frame_end  = 1'b1;
                res.frame_good = (byte_in == xor_reg);
                phase_next     = PH_HUNT;
            end
            default: begin
                phase_next = (byte_in == start_byte) ? PH_TYPE : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            type_reg   <= '0;
            length_reg <= '0;
            count_reg  <= '0;
            xor_reg    <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            xor_reg    <= xor_next;
        end
    end

endmodule

>>> hw/rtl/sof_length_xor_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// sof_length_xor_frame_parser_unit
// Start-of-frame / length / XOR checksum deframer for a serial byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one received serial byte per beat. Bytes are ignored until
//   the start byte, then type, length, payload and checksum are taken.
//   m_* channel: one beat per payload byte (m_tlast low), carrying the byte,
//   its index, the frame type and length; and one end beat on the checksum
//   byte (m_tlast high, m_tuser = checksum good). Downstream commits or drops
//   the frame on the end beat. Length bytes above max_length abort silently.
//   cfg_*: start_byte (index 0) and max_length (index 1), written while idle.
// Path: an accepted byte is registered in the input register, then passes
//   the parser logic into the result register that drives m_*.
// Throughput: one beat per cycle while m_tready stays high; the parser
//   state updates on every step.
// Reset: parser returns to hunting, held fields clear, registers go to
//   start_byte 0xAA and max_length 250.
// Stall: a valid result holds in the result register while m_tready is low.
//   Bytes that give no result (hunting, type, length) keep flowing; the first
//   result byte waits in the input register; s_tready drops until m_* drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sof_length_xor_frame_parser_unit
    import sflx_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] byte_in

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                            // [23:16] frame_type, [31:24] frame_length
    output logic                 m_tlast,   // frame_end
    output logic                 m_tuser    // [0] frame_good
);

    // Configuration registers
    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] max_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= START_BYTE_RST;
            max_length_reg <= MAX_LENGTH_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_START_BYTE: start_byte_reg <= cfg_wdata[BYTE_W-1:0];
                CFG_MAX_LENGTH: max_length_reg <= cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Result register
    logic              out_valid_reg;
    sflx_result_t      out_reg;

    logic              out_free;
    logic              res_valid;
    sflx_result_t      res;
    logic              step;

    // Output slot can take a new beat when empty or draining now
    assign out_free = !out_valid_reg || m_tready;
    // Bytes that yield nothing never wait on the output side
    assign step     = in_valid_reg && (out_free || !res_valid);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    sflx_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .byte_in    (in_byte_reg),
        .start_byte (start_byte_reg),
        .max_length (max_length_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.frame_length, out_reg.frame_type,
                       out_reg.byte_index, out_reg.data_byte};
    assign m_tlast  = out_reg.frame_end;
    assign m_tuser  = out_reg.frame_good;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_IMPL(a_end_beat_clear, m_tvalid && m_tlast, m_tdata[15:0] == '0,
                 "end beat carries payload data or index")
    `ASSERT_IMPL(a_good_only_on_end, m_tvalid && !m_tlast, !m_tuser,
                 "good flag set on a payload beat")
    `ASSERT_NEXT(a_accept_captured, s_tvalid && s_tready, in_valid_reg,
                 "accepted byte not held in input register")
    `ASSERT_NEXT(a_no_overwrite, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
                 "stalled result lost or overwritten")

endmodule

>>> tb/sv/tb_sof_length_xor_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sof_length_xor_frame_parser_unit
// Self-checking bench for the start/length/XOR-checksum frame deframer. Byte
// streams of noise, good frames, bad-checksum frames and over-length aborts
// are driven into s_*; a local parser model predicts each m_* beat, and every
// beat is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sof_length_xor_frame_parser_unit;
    import sflx_pkg::*;

    // Cycles with nothing accepted before the run is declared hung.
    localparam int STUCK_LIMIT = 3000;
    // Length of the one-shot receiver hold-off that backs up the pipeline.
    localparam int HOLD_CYCLES = 150;

    // Local copy of the parser phases.
    typedef enum logic [2:0] {
        P_HUNT, P_TYPE, P_LEN, P_BODY, P_CHECK
    } parse_ph_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_START_BYTE;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;   // [7:0] byte_in
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;          // [7:0] data_byte, [15:8] byte_index,
                                            // [23:16] frame_type, [31:24] frame_length
    logic                 m_tlast;          // frame_end
    logic                 m_tuser;          // [0] frame_good

    sof_length_xor_frame_parser_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Serial bytes still to be offered, and beats the parser model says are due.
    logic [7:0]   byte_q[$];
    sflx_result_t beat_q[$];

    // Model copy of the registers (also steers stimulus generation).
    logic [7:0] cur_sof = START_BYTE_RST;
    logic [7:0] cur_max = MAX_LENGTH_RST;

    // Model copy of the parser state, reset values.
    parse_ph_t  ps        = P_HUNT;
    logic [7:0] held_type = '0;
    logic [7:0] held_len  = '0;
    logic [7:0] body_cnt  = '0;
    logic [7:0] run_xor   = '0;

    // Idle odds in percent per cycle; pressure arms the long receiver hold.
    int snd_idle_pct = 21;
    int rcv_idle_pct = 69;
    bit press_armed  = 1'b0;

    int err_cnt   = 0;
    int stuck_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got_v, want_v, $time);
        err_cnt++;
    endtask

    // Parser model: advance one byte, queue the beat it produces (if any).
    task automatic parse_byte(input logic [7:0] b);
        sflx_result_t r;
        r = '0;
        case (ps)
            P_TYPE: begin
                held_type = b;
                run_xor   = b;
                ps        = P_LEN;
            end
            P_LEN: begin
                held_len = b;
                if (b > cur_max) begin
                    ps = P_HUNT;        // over-length: silent abort
                end else begin
                    run_xor  = run_xor ^ b;
                    body_cnt = '0;
                    ps       = (b == 8'd0) ? P_CHECK : P_BODY;
                end
            end
            P_BODY: begin
                r.data_byte    = b;
                r.byte_index   = body_cnt;
                r.frame_type   = held_type;
                r.frame_length = held_len;
                beat_q.push_back(r);
                run_xor  = run_xor ^ b;
                body_cnt = body_cnt + 8'd1;
                if (body_cnt >= held_len) ps = P_CHECK;
            end
            P_CHECK: begin
                r.frame_type   = held_type;
                r.frame_length = held_len;
                r.frame_end    = 1'b1;
                r.frame_good   = (b == run_xor);
                beat_q.push_back(r);
                ps = P_HUNT;
            end
            default: begin
                ps = (b == cur_sof) ? P_TYPE : P_HUNT;
            end
        endcase
    endtask

    // Queue one frame. Over-length frames stop after the length byte, since
    // the parser is back to hunting from there.
    task automatic push_frame(input logic [7:0] typ, input int len, input bit corrupt);
        logic [7:0] x;
        logic [7:0] pb;
        byte_q.push_back(cur_sof);
        byte_q.push_back(typ);
        byte_q.push_back(8'(len));
        if (len <= cur_max) begin
            x = typ ^ 8'(len);
            for (int i = 0; i < len; i++) begin
                pb = 8'($urandom_range(0, 255));
                x  = x ^ pb;
                byte_q.push_back(pb);
            end
            if (corrupt) x = x ^ 8'(1 << $urandom_range(0, 7));
            byte_q.push_back(x);
        end
    endtask

    // Mostly well-formed frames with random content, some noise, aborts and
    // bad checksums. Budget counts frame bytes only, not the noise bytes.
    task automatic gen_traffic(input int budget);
        int sent;
        int pick;
        int len;
        int lim;
        sent = 0;
        lim  = (cur_max < 6) ? int'(cur_max) : 6;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                byte_q.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 24 && cur_max < 8'd255) begin
                len = $urandom_range(int'(cur_max) + 1, 255);
                push_frame(8'($urandom_range(0, 255)), len, 1'b0);
                sent += 3;
            end else begin
                len = $urandom_range(0, lim);
                push_frame(8'($urandom_range(0, 255)), len, $urandom_range(0, 99) < 15);
                sent += len + 4;
            end
        end
    endtask

    // Block idle: all bytes taken, all beats back, plus pipeline latency for
    // bytes that produce no beat.
    task automatic wait_drained();
        while (byte_q.size() != 0 || s_tvalid || beat_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_START_BYTE) cur_sof = val;
        else                       cur_max = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Sender: hold the beat until taken, then pull the next byte or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (byte_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random ready, plus one long hold-off once pressure is armed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (press_armed && !hold_done && m_tvalid) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Monitor: check result beats, then feed accepted input bytes to the model.
    // A byte passes the input and result registers to reach the output, so the order here is safe.
    always @(posedge aclk) begin : mon
        sflx_result_t got;
        sflx_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tlast, m_tdata};
                if (beat_q.size() == 0) begin
                    report_mismatch("beat with nothing expected", m_tdata, 0);
                end else begin
                    want = beat_q.pop_front();
                    if (got.data_byte != want.data_byte)
                        report_mismatch("data_byte", got.data_byte, want.data_byte);
                    if (got.byte_index != want.byte_index)
                        report_mismatch("byte_index", got.byte_index, want.byte_index);
                    if (got.frame_type != want.frame_type)
                        report_mismatch("frame_type", got.frame_type, want.frame_type);
                    if (got.frame_length != want.frame_length)
                        report_mismatch("frame_length", got.frame_length, want.frame_length);
                    if (got.frame_end != want.frame_end)
                        report_mismatch("frame_end", got.frame_end, want.frame_end);
                    if (got.frame_good != want.frame_good)
                        report_mismatch("frame_good", got.frame_good, want.frame_good);
                end
            end
            if (s_tvalid && s_tready) parse_byte(s_tdata);
        end
    end

    // Watchdog: counts only while work is outstanding.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (byte_q.size() == 0 && !s_tvalid && beat_q.size() == 0)) begin
            stuck_cnt <= 0;
        end else if (stuck_cnt >= STUCK_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stuck_cnt <= stuck_cnt + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- Phase 1: sender idles 21%, receiver 69%, reset register values.
        // Noise while hunting.
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h55);
        // Zero-length frame: length straight to checksum.
        push_frame(8'hFF, 0, 1'b0);
        // Start byte value inside the payload is plain data.
        byte_q.push_back(8'hAA);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h03);
        byte_q.push_back(8'hAA);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h56);
        // Length one above the limit: silent abort.
        byte_q.push_back(8'hAA);
        byte_q.push_back(8'h5A);
        byte_q.push_back(8'hFB);
        // Bad checksum still gives an end beat, good flag low.
        push_frame(8'h81, 1, 1'b1);
        // Register change mid-frame: limit drops to 2 before the length byte.
        byte_q.push_back(8'hAA);
        byte_q.push_back(8'h12);
        wait_drained();
        write_reg(CFG_MAX_LENGTH, 8'd2);
        byte_q.push_back(8'h03);
        wait_drained();

        write_reg(CFG_START_BYTE, 8'hAA);
        write_reg(CFG_MAX_LENGTH, 8'd250);
        gen_traffic(60);
        wait_drained();

        // ---- Phase 2: idle odds swapped, start byte 0x00, no payload allowed.
        snd_idle_pct = 69;
        rcv_idle_pct = 21;
        write_reg(CFG_START_BYTE, 8'h00);
        write_reg(CFG_MAX_LENGTH, 8'd0);
        gen_traffic(40);
        wait_drained();

        // ---- Phase 3: no idling; full-length frame while the receiver holds off.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(CFG_START_BYTE, 8'hFF);
        write_reg(CFG_MAX_LENGTH, 8'd255);
        press_armed = 1'b1;
        push_frame(8'($urandom_range(0, 255)), 255, 1'b0);
        gen_traffic(20);
        wait_drained();

        write_reg(CFG_START_BYTE, 8'($urandom_range(0, 255)));
        write_reg(CFG_MAX_LENGTH, 8'($urandom_range(1, 12)));
        gen_traffic(45);
        wait_drained();

        // Trailing window for any stray beat.
        repeat (8) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sof_length_xor_frame_parser_unit.f
+incdir+hw/rtl
hw/rtl/sflx_pkg.sv
hw/rtl/sflx_parser.sv
hw/rtl/sof_length_xor_frame_parser_unit.sv
tb/sv/tb_sof_length_xor_frame_parser_unit.sv
